[design/mhs_pkg.sv]
// Shared widths, types and codes for the Moore-Hodgson job selector.
package mhs_pkg;

  localparam int TIME_W = 24;
  localparam int KEPT_W = 11;

  typedef enum logic [1:0] {
    OP_HOLD = 2'd0,
    OP_INS  = 2'd1,
    OP_POP  = 2'd2
  } cell_op_t;

  typedef struct packed {
    cell_op_t            op;
    logic [TIME_W-1:0]   val;
  } cell_cmd_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_INS  = 3'b010,
    S_POP  = 3'b100
  } state_t;

endpackage

[design/moore_hodgson_max_heap_scheduler.sv]
// Moore-Hodgson job selector top level: input/output stages, control and the cell row.
// After the input transfer the job passes the insert step of the cell row, then the drop
// step; result tvalid is registered as the drop step ends, and s_tready stays low until then.
// Insert shifts cells past the insertion point by one cell; drop shifts the whole row.
// A stalled result holds the drop step, and with it the next input transfer.
// Reset clears the kept count, the running total and the handshake; cell contents are
// undefined until written and only occupied cells are ever looked at.
module moore_hodgson_max_heap_scheduler
  import mhs_pkg::*;
#(
  parameter int HEAP_DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // job_time[23:0], job_deadline[47:24]
  input  logic        s_tuser,   // start_set
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // kept_count[10:0], dropped_time[34:11], zero fill
  output logic [1:0]  m_tuser    // dropped[0], overflow[1]
);

  localparam int SW = $clog2(HEAP_DEPTH + 1);
  localparam int TW = TIME_W + SW;

  state_t            state;
  logic              start_r;
  logic [TIME_W-1:0] time_r;
  logic [TIME_W-1:0] dl_r;
  logic              ovf_r;
  logic [SW-1:0]     size;
  logic [TW-1:0]     total;

  logic [KEPT_W-1:0] out_kept;
  logic              out_drop;
  logic [TIME_W-1:0] out_dtime;
  logic              out_ovf;

  logic [SW-1:0]     eff_size;
  logic              ovf_now;
  logic              slot_free;
  logic              need_pop;
  logic              pop_now;
  cell_cmd_t         cmd;

  logic [TIME_W-1:0] cval [HEAP_DEPTH];
  logic              cge  [HEAP_DEPTH];
  logic              used [HEAP_DEPTH];

  assign s_tready  = (state == S_IDLE);
  assign eff_size  = (state == S_INS && start_r) ? '0 : size;
  assign ovf_now   = (eff_size == SW'(HEAP_DEPTH));
  assign slot_free = !m_tvalid || m_tready;
  assign need_pop  = !ovf_r && (total > TW'(dl_r));
  assign pop_now   = (state == S_POP) && slot_free && need_pop;

  always_comb begin
    cmd.val = time_r;
    cmd.op  = OP_HOLD;
    if (state == S_INS && !ovf_now) cmd.op = OP_INS;
    else if (pop_now)               cmd.op = OP_POP;
  end

  genvar gi;
  generate
    for (gi = 0; gi < HEAP_DEPTH; gi++) begin : g_cell
      logic [TIME_W-1:0] pv;
      logic              pg;
      logic [TIME_W-1:0] nv;
      assign used[gi] = SW'(gi) < eff_size;
      if (gi == 0) begin : g_head
        assign pv = '0;
        assign pg = 1'b1;
      end else begin : g_body
        assign pv = cval[gi-1];
        assign pg = cge[gi-1];
      end
      if (gi == HEAP_DEPTH - 1) begin : g_tail
        assign nv = '0;
      end else begin : g_link
        assign nv = cval[gi+1];
      end
      mhs_cell u_cell (
        .clk      (clk),
        .cmd      (cmd),
        .used     (used[gi]),
        .prev_val (pv),
        .prev_ge  (pg),
        .next_val (nv),
        .val      (cval[gi]),
        .ge       (cge[gi])
      );
    end
  endgenerate

  // control and state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      size  <= '0;
      total <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) state <= S_INS;
        end
        S_INS: begin
          if (ovf_now) begin
            size <= eff_size;
          end else begin
            size  <= eff_size + SW'(1);
            total <= (start_r ? '0 : total) + TW'(time_r);
          end
          state <= S_POP;
        end
        S_POP: begin
          if (slot_free) begin
            if (need_pop) begin
              size  <= size - SW'(1);
              total <= total - TW'(cval[0]);
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // input job register
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      start_r <= s_tuser;
      time_r  <= s_tdata[23:0];
      dl_r    <= s_tdata[47:24];
    end
    if (state == S_INS) ovf_r <= ovf_now;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_POP && slot_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_POP && slot_free) begin
      out_kept  <= KEPT_W'(need_pop ? size - SW'(1) : size);
      out_drop  <= need_pop;
      out_dtime <= need_pop ? cval[0] : '0;
      out_ovf   <= ovf_r;
    end
  end

  assign m_tdata = {5'd0, out_dtime, out_kept};
  assign m_tuser = {out_ovf, out_drop};

  a_size_bound: assert property (@(posedge clk) disable iff (rst)
    size <= SW'(HEAP_DEPTH))
    else $error("kept count beyond heap depth");

  a_ovf_no_drop: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(out_ovf && out_drop))
    else $error("refused job also reports a drop");

  a_dtime_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !out_drop) |-> (out_dtime == '0))
    else $error("dropped time nonzero without a drop");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (rst)
    pop_now |=> (size == $past(size) - SW'(1)))
    else $error("drop step did not shrink the kept set");

endmodule

[design/mhs_cell.sv]
// One cell of the sorted row: holds one kept time, largest times toward cell 0.
module mhs_cell
  import mhs_pkg::*;
(
  input  logic              clk,
  input  cell_cmd_t         cmd,
  input  logic              used,
  input  logic [TIME_W-1:0] prev_val,
  input  logic              prev_ge,
  input  logic [TIME_W-1:0] next_val,
  output logic [TIME_W-1:0] val,
  output logic              ge
);

  logic [TIME_W-1:0] val_next;

  // ge: this cell is occupied and not smaller than the incoming time
  assign ge = used && (val >= cmd.val);

  always_comb begin
    val_next = val;
    case (cmd.op)
      OP_INS: begin
        if (!ge) val_next = prev_ge ? cmd.val : prev_val;
      end
      OP_POP:  val_next = next_val;
      default: val_next = val;
    endcase
  end

  always_ff @(posedge clk) begin
    val <= val_next;
  end

endmodule
